// File: rtl/dnsa_pkg.sv
package dnsa_pkg;

  localparam int unsigned MaxReplyBytesDef = 512;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned FieldW = 4;
  localparam int unsigned AddrW = 32;

  // header byte positions
  localparam int unsigned PosQdcountHi = 4;
  localparam int unsigned PosQdcountLo = 5;
  localparam int unsigned PosAncountHi = 6;
  localparam int unsigned PosAncountLo = 7;
  localparam int unsigned PosHeaderEnd = 11;

  localparam logic [ByteW-1:0] PtrMask = 8'hC0;
  localparam logic [CountW-1:0] QtailLen = 16'd4;
  localparam logic [CountW-1:0] TypeA = 16'd1;
  localparam logic [CountW-1:0] Ipv4Len = 16'd4;

  // fixed part of an answer record: type, class, ttl, rdlength
  localparam logic [FieldW-1:0] FiTypeHi = 4'd0;
  localparam logic [FieldW-1:0] FiTypeLo = 4'd1;
  localparam logic [FieldW-1:0] FiRdlenHi = 4'd8;
  localparam logic [FieldW-1:0] FiRdlenLo = 4'd9;
  localparam logic [FieldW-1:0] FiAddrLast = 4'd3;

  typedef enum logic [7:0] {
    PH_HEADER = 8'b0000_0001,
    PH_QNAME  = 8'b0000_0010,
    PH_QTAIL  = 8'b0000_0100,
    PH_LABEL  = 8'b0000_1000,
    PH_ANAME  = 8'b0001_0000,
    PH_AFIXED = 8'b0010_0000,
    PH_RDATA  = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] address;
  } out_word_t;

  typedef struct packed {
    logic     valid;
    in_word_t word;
  } stage_t;

endpackage

// File: rtl/dnsa_in_reg.sv
module dnsa_in_reg
  import dnsa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_word_t in_word_i,
  output logic     in_stall_o,
  input  logic     take_i,
  output stage_t   stage_o
);

  logic     valid_q, valid_d;
  in_word_t word_q, word_d;

  assign in_stall_o = valid_q && !take_i;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
      word_d  = in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign stage_o.valid = valid_q;
  assign stage_o.word  = word_q;

endmodule

// File: rtl/dnsa_parser.sv
module dnsa_parser
  import dnsa_pkg::*;
#(
  parameter int unsigned MAX_REPLY_BYTES = MaxReplyBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  stage_t    stage_i,
  input  logic      take_i,
  output out_word_t result_o
);

  localparam int unsigned PosW = $clog2(MAX_REPLY_BYTES + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_REPLY_BYTES);

  logic [PosW-1:0]   pos_q, pos_d;
  phase_e            phase_q, phase_d;
  logic [CountW-1:0] qleft_q, qleft_d;
  logic [CountW-1:0] aleft_q, aleft_d;
  logic [CountW-1:0] skip_q, skip_d;
  logic [FieldW-1:0] fidx_q, fidx_d;
  logic [CountW-1:0] rtype_q, rtype_d;
  logic [CountW-1:0] rdlen_q, rdlen_d;
  logic [AddrW-1:0]  acc_q, acc_d;
  logic              found_q, found_d;
  logic [AddrW-1:0]  faddr_q, faddr_d;

  logic [ByteW-1:0]  c;
  logic [CountW-1:0] skip_dec, qleft_dec, aleft_dec, rdlen_new;
  logic [AddrW-1:0]  acc_new;
  logic              name_end, a_match;

  assign c         = stage_i.word.data_byte;
  assign skip_dec  = skip_q - 16'd1;
  assign qleft_dec = qleft_q - 16'd1;
  assign aleft_dec = aleft_q - 16'd1;
  assign rdlen_new = {rdlen_q[CountW-1:ByteW], c};
  assign acc_new   = acc_q | ({24'h0, c} << {fidx_q[1:0], 3'b000});
  assign name_end  = (c == 8'h00) || ((c & PtrMask) == PtrMask);
  assign a_match   = (rtype_q == TypeA) && (rdlen_q == Ipv4Len);

  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    qleft_d = qleft_q;
    aleft_d = aleft_q;
    skip_d  = skip_q;
    fidx_d  = fidx_q;
    rtype_d = rtype_q;
    rdlen_d = rdlen_q;
    acc_d   = acc_q;
    found_d = found_q;
    faddr_d = faddr_q;
    if (pos_q < PosMax) begin
      pos_d = pos_q + 1'b1;
      unique case (phase_q)
        PH_HEADER: begin
          if (pos_q == PosW'(PosQdcountHi)) begin
            qleft_d = {c, 8'h00};
          end else if (pos_q == PosW'(PosQdcountLo)) begin
            qleft_d = {qleft_q[CountW-1:ByteW], c};
          end else if (pos_q == PosW'(PosAncountHi)) begin
            aleft_d = {c, 8'h00};
          end else if (pos_q == PosW'(PosAncountLo)) begin
            aleft_d = {aleft_q[CountW-1:ByteW], c};
          end else if (pos_q == PosW'(PosHeaderEnd)) begin
            if (aleft_q == '0) begin
              phase_d = PH_DONE;
            end else begin
              phase_d = (qleft_q != '0) ? PH_QNAME : PH_ANAME;
            end
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (name_end) begin
            if (qleft_q != '0) begin
              phase_d = PH_QTAIL;
              skip_d  = QtailLen + {15'd0, c != 8'h00};
            end else begin
              phase_d = PH_AFIXED;
              skip_d  = {15'd0, c != 8'h00};
              fidx_d  = '0;
            end
          end else begin
            phase_d = PH_LABEL;
            skip_d  = {8'h00, c};
          end
        end
        PH_LABEL: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d = (qleft_q != '0) ? PH_QNAME : PH_ANAME;
          end
        end
        PH_QTAIL: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            qleft_d = qleft_dec;
            phase_d = (qleft_dec == '0) ? PH_ANAME : PH_QNAME;
          end
        end
        PH_AFIXED: begin
          if (skip_q != '0) begin
            skip_d = skip_dec;
          end else begin
            if (fidx_q == FiTypeHi) begin
              rtype_d = {c, 8'h00};
            end else if (fidx_q == FiTypeLo) begin
              rtype_d = {rtype_q[CountW-1:ByteW], c};
            end else if (fidx_q == FiRdlenHi) begin
              rdlen_d = {c, 8'h00};
            end else if (fidx_q == FiRdlenLo) begin
              rdlen_d = rdlen_new;
            end
            if (fidx_q == FiRdlenLo) begin
              fidx_d = '0;
              if ((rtype_q == TypeA) && (rdlen_new == Ipv4Len)) begin
                acc_d   = '0;
                phase_d = PH_RDATA;
              end else if (rdlen_new == '0) begin
                aleft_d = aleft_dec;
                phase_d = (aleft_dec == '0) ? PH_DONE : PH_ANAME;
              end else begin
                skip_d  = rdlen_new;
                phase_d = PH_RDATA;
              end
            end else begin
              fidx_d = fidx_q + 1'b1;
            end
          end
        end
        PH_RDATA: begin
          if (a_match) begin
            acc_d = acc_new;
            if (fidx_q >= FiAddrLast) begin
              found_d = 1'b1;
              faddr_d = acc_new;
              phase_d = PH_DONE;
            end else begin
              fidx_d = fidx_q + 1'b1;
            end
          end else begin
            skip_d = skip_dec;
            if (skip_dec == '0) begin
              aleft_d = aleft_dec;
              phase_d = (aleft_dec == '0) ? PH_DONE : PH_ANAME;
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign result_o.found   = found_d;
  assign result_o.address = found_d ? faddr_d : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PH_HEADER;
      qleft_q <= '0;
      aleft_q <= '0;
      skip_q  <= '0;
      fidx_q  <= '0;
      rtype_q <= '0;
      rdlen_q <= '0;
      acc_q   <= '0;
      found_q <= 1'b0;
      faddr_q <= '0;
    end else if (take_i) begin
      if (stage_i.word.last_byte) begin
        pos_q   <= '0;
        phase_q <= PH_HEADER;
        qleft_q <= '0;
        aleft_q <= '0;
        skip_q  <= '0;
        fidx_q  <= '0;
        rtype_q <= '0;
        rdlen_q <= '0;
        acc_q   <= '0;
        found_q <= 1'b0;
        faddr_q <= '0;
      end else begin
        pos_q   <= pos_d;
        phase_q <= phase_d;
        qleft_q <= qleft_d;
        aleft_q <= aleft_d;
        skip_q  <= skip_d;
        fidx_q  <= fidx_d;
        rtype_q <= rtype_d;
        rdlen_q <= rdlen_d;
        acc_q   <= acc_d;
        found_q <= found_d;
        faddr_q <= faddr_d;
      end
    end
  end

endmodule

// File: rtl/dnsa_out_reg.sv
module dnsa_out_reg
  import dnsa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_word_t result_i,
  output logic      free_o,
  output logic      out_valid_o,
  output out_word_t out_word_o,
  input  logic      out_stall_i
);

  logic      valid_q, valid_d;
  out_word_t word_q, word_d;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    word_d  = word_q;
    if (load_i) begin
      valid_d = 1'b1;
      word_d  = result_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

// File: rtl/dns_a_record_extractor.sv
// DNS reply parser that returns the first IPv4 A record. Feed the reply one
// byte per word with last_byte on its final byte; exactly one result word
// follows each reply: found, and the address with the first data byte in
// bits 7:0 (zero when not found). Each result passes through an input
// register and a result register. A byte is taken every cycle, except
// that a waiting last byte holds the input side while the result register
// is full and stalled; nothing else holds it. Bytes beyond MAX_REPLY_BYTES
// are ignored apart from their last_byte mark.
module dns_a_record_extractor
  import dnsa_pkg::*;
#(
  parameter int unsigned MAX_REPLY_BYTES = MaxReplyBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_word_t  in_word_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output out_word_t out_word_o,
  input  logic      out_stall_i
);

  stage_t    stage;
  out_word_t result;
  logic      take, out_free;

  // hold a last byte until the result register can take its result
  assign take = stage.valid && (!stage.word.last_byte || out_free);

  dnsa_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .take_i     (take),
    .stage_o    (stage)
  );

  dnsa_parser #(
    .MAX_REPLY_BYTES (MAX_REPLY_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (stage),
    .take_i   (take),
    .result_o (result)
  );

  dnsa_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && stage.word.last_byte),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// File: rtl/dnsa_checker.sv
module dnsa_assertions
  import dnsa_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_i,
  input logic      out_valid_i,
  input out_word_t out_word_i,
  input logic      out_stall_i
);

  a_addr_zero_when_not_found: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_word_i.found |-> out_word_i.address == '0
  ) else $error("address nonzero on a not-found result");

  a_stall_only_on_full_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> out_valid_i && out_stall_i
  ) else $error("input stalled while the result side is free");

  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_word_i)
  ) else $error("stalled result word changed or dropped");

endmodule

bind dns_a_record_extractor dnsa_assertions u_dnsa_assertions (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_word_i  (out_word_o),
  .out_stall_i (out_stall_i)
);

// File: tb/sv/dnsa_checker.sv
module dnsa_checker
  import dnsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  in_word_t    in_word_i,
  input  logic        in_stall_i,
  input  logic        out_valid_i,
  input  out_word_t   out_word_i,
  input  logic        out_stall_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  out_word_t         reply_q[$];
  int unsigned       fails = 0;

  int unsigned       pos = 0;
  phase_e            ph = PH_HEADER;
  logic [CountW-1:0] q_left = '0;
  logic [CountW-1:0] a_left = '0;
  logic [CountW-1:0] skip = '0;
  logic [CountW-1:0] rtype = '0;
  logic [CountW-1:0] rdlen = '0;
  logic [FieldW-1:0] fidx = '0;
  logic [AddrW-1:0]  acc = '0;
  logic [AddrW-1:0]  hit_addr = '0;
  logic              hit = 1'b0;
  logic [ByteW-1:0]  c;
  out_word_t         want;

  task automatic clear_parse();
    pos = 0;
    ph = PH_HEADER;
    q_left = '0;
    a_left = '0;
    skip = '0;
    rtype = '0;
    rdlen = '0;
    fidx = '0;
    acc = '0;
    hit_addr = '0;
    hit = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [AddrW-1:0] got,
                                 input logic [AddrW-1:0] exp_val);
    $display("%0t: %s: got %h, want %h", $time, what, got, exp_val);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      reply_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          report_mismatch("result word with no reply pending", out_word_i.address, '0);
        end else begin
          want = reply_q.pop_front();
          if (out_word_i.found !== want.found) begin
            report_mismatch("found", AddrW'(out_word_i.found), AddrW'(want.found));
          end
          if (out_word_i.address !== want.address) begin
            report_mismatch("address", out_word_i.address, want.address);
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        c = in_word_i.data_byte;
        if (pos < MaxReplyBytesDef) begin
          case (ph)
            PH_HEADER: begin
              if (pos == PosQdcountHi) q_left = {c, 8'h00};
              else if (pos == PosQdcountLo) q_left = q_left | CountW'(c);
              else if (pos == PosAncountHi) a_left = {c, 8'h00};
              else if (pos == PosAncountLo) a_left = a_left | CountW'(c);
              else if (pos == PosHeaderEnd) begin
                if (a_left == '0) ph = PH_DONE;
                else ph = (q_left != '0) ? PH_QNAME : PH_ANAME;
              end
            end
            PH_QNAME, PH_ANAME: begin
              if (c == 8'h00 || (c & PtrMask) == PtrMask) begin
                if (q_left != '0) begin
                  ph = PH_QTAIL;
                  skip = (c == 8'h00) ? QtailLen : QtailLen + 16'd1;
                end else begin
                  ph = PH_AFIXED;
                  skip = (c == 8'h00) ? 16'd0 : 16'd1;
                  fidx = '0;
                end
              end else begin
                ph = PH_LABEL;
                skip = CountW'(c);
              end
            end
            PH_LABEL: begin
              skip = skip - 16'd1;
              if (skip == '0) ph = (q_left != '0) ? PH_QNAME : PH_ANAME;
            end
            PH_QTAIL: begin
              skip = skip - 16'd1;
              if (skip == '0) begin
                q_left = q_left - 16'd1;
                ph = (q_left == '0) ? PH_ANAME : PH_QNAME;
              end
            end
            PH_AFIXED: begin
              if (skip != '0) begin
                skip = skip - 16'd1;
              end else begin
                if (fidx == FiTypeHi) rtype = {c, 8'h00};
                else if (fidx == FiTypeLo) rtype = rtype | CountW'(c);
                else if (fidx == FiRdlenHi) rdlen = {c, 8'h00};
                else if (fidx == FiRdlenLo) rdlen = rdlen | CountW'(c);
                if (fidx == FiRdlenLo) begin
                  fidx = '0;
                  if (rtype == TypeA && rdlen == Ipv4Len) begin
                    acc = '0;
                    ph = PH_RDATA;
                  end else if (rdlen == '0) begin
                    a_left = a_left - 16'd1;
                    ph = (a_left == '0) ? PH_DONE : PH_ANAME;
                  end else begin
                    skip = rdlen;
                    ph = PH_RDATA;
                  end
                end else begin
                  fidx = fidx + 4'd1;
                end
              end
            end
            PH_RDATA: begin
              if (rtype == TypeA && rdlen == Ipv4Len) begin
                acc = acc | (AddrW'(c) << {fidx[1:0], 3'b000});
                if (fidx >= FiAddrLast) begin
                  hit = 1'b1;
                  hit_addr = acc;
                  ph = PH_DONE;
                end else begin
                  fidx = fidx + 4'd1;
                end
              end else begin
                skip = skip - 16'd1;
                if (skip == '0) begin
                  a_left = a_left - 16'd1;
                  ph = (a_left == '0) ? PH_DONE : PH_ANAME;
                end
              end
            end
            default: begin
            end
          endcase
          pos++;
        end
        if (in_word_i.last_byte) begin
          want.found = hit;
          want.address = hit ? hit_addr : '0;
          reply_q.push_back(want);
          clear_parse();
        end
      end

      fail_count_o <= fails;
      pending_o <= reply_q.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
module tb;
  import dnsa_pkg::*;

  localparam logic [CountW-1:0] TypeCname = 16'd5;
  localparam logic [CountW-1:0] TypeTxt = 16'd16;
  localparam logic [CountW-1:0] TypeAaaa = 16'd28;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  in_word_t    in_word = '0;
  logic        in_stall;
  logic        out_valid;
  out_word_t   out_word;
  logic        out_stall = 1'b0;
  int unsigned fail_count;
  int unsigned pending;

  logic [7:0]  pkt[$];
  int          burst_left = 0;
  int          sent = 0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;

  dns_a_record_extractor i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_word_i  (in_word),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_word_o (out_word),
    .out_stall_i(out_stall)
  );

  dnsa_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_word_i   (in_word),
    .in_stall_i  (in_stall),
    .out_valid_i (out_valid),
    .out_word_i  (out_word),
    .out_stall_i (out_stall),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic add_random(input int n);
    repeat (n) pkt.push_back(8'($urandom));
  endtask

  task automatic add_header(input logic [CountW-1:0] qd, input logic [CountW-1:0] an);
    add_random(4);
    pkt.push_back(qd[15:8]);
    pkt.push_back(qd[7:0]);
    pkt.push_back(an[15:8]);
    pkt.push_back(an[7:0]);
    add_random(4);
  endtask

  task automatic add_name();
    int n_lab;
    int len;
    n_lab = $urandom_range(0, 3);
    repeat (n_lab) begin
      len = ($urandom_range(0, 99) == 0) ? $urandom_range(64, 191) : $urandom_range(1, 12);
      pkt.push_back(8'(len));
      add_random(len);
    end
    if ($urandom_range(0, 2) == 0) begin
      pkt.push_back(8'h00);
    end else begin
      pkt.push_back(PtrMask | 8'($urandom_range(0, 63)));
      add_random(1);
    end
  endtask

  task automatic add_record(input logic [CountW-1:0] rtype, input logic [CountW-1:0] rdl);
    add_name();
    pkt.push_back(rtype[15:8]);
    pkt.push_back(rtype[7:0]);
    add_random(6);
    pkt.push_back(rdl[15:8]);
    pkt.push_back(rdl[7:0]);
    add_random(int'(rdl));
  endtask

  task automatic set_address(input logic [AddrW-1:0] addr);
    for (int k = 0; k < 4; k++) pkt[pkt.size() - 4 + k] = addr[8*k +: 8];
  endtask

  task automatic add_question();
    add_name();
    add_random(4);
  endtask

  task automatic build_reply();
    int shape;
    int qd;
    int an;
    int kind;
    int cut;
    pkt.delete();
    shape = $urandom_range(0, 19);
    if (shape == 0) begin
      add_random($urandom_range(1, 30));
    end else if (shape == 1) begin
      add_header(16'($urandom), 16'($urandom));
      add_random($urandom_range(0, 60));
    end else begin
      qd = $urandom_range(0, 2);
      an = $urandom_range(0, 3);
      add_header(16'(qd), 16'(an));
      repeat (qd) add_question();
      repeat (an) begin
        kind = $urandom_range(0, 9);
        case (kind)
          5: add_record(TypeA, 16'($urandom_range(0, 8)));
          6: add_record(TypeCname, 16'($urandom_range(0, 12)));
          7: add_record(TypeAaaa, 16'd16);
          8: add_record(16'($urandom), 16'($urandom_range(0, 6)));
          9: add_record(16'($urandom_range(0, 3)), Ipv4Len);
          default: add_record(TypeA, Ipv4Len);
        endcase
      end
      if (shape < 5) begin
        cut = $urandom_range(1, pkt.size());
        while (pkt.size() > cut) void'(pkt.pop_back());
      end else if (shape < 7) begin
        add_random($urandom_range(1, 8));
      end
    end
  endtask

  task automatic send_reply();
    for (int i = 0; i < pkt.size(); i++) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 20);
      end
      in_valid <= 1'b1;
      in_word <= '{data_byte: pkt[i], last_byte: (i == pkt.size() - 1)};
      @(posedge clk_i);
      while (in_stall) @(posedge clk_i);
      burst_left--;
      sent++;
    end
  endtask

  initial begin
    int mode;
    int len;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(1, 40);
      repeat (len) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'b1;
          2: out_stall <= 1'($urandom);
          default: out_stall <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    pkt = '{8'hFF};
    send_reply();

    pkt.delete();
    add_header(16'd1, 16'd1);
    void'(pkt.pop_back());
    send_reply();

    pkt.delete();
    add_header(16'd1, 16'd0);
    send_reply();

    pkt.delete();
    add_header(16'd0, 16'd1);
    add_record(TypeA, Ipv4Len);
    set_address(32'h0100000A);
    add_random(3);
    send_reply();

    pkt.delete();
    add_header(16'd0, 16'd1);
    add_record(TypeA, Ipv4Len);
    void'(pkt.pop_back());
    send_reply();

    pkt.delete();
    add_header(16'd2, 16'd2);
    pkt.push_back(8'h40);
    add_random(64);
    pkt.push_back(8'h00);
    add_random(4);
    pkt.push_back(8'hC0);
    pkt.push_back(8'h0C);
    add_random(4);
    add_record(TypeCname, 16'd0);
    add_record(TypeA, Ipv4Len);
    set_address(32'hFFFFFFFF);
    send_reply();

    pkt.delete();
    add_header(16'd1, 16'd3);
    add_question();
    add_record(TypeA, 16'd16);
    add_record(TypeAaaa, Ipv4Len);
    add_record(TypeA, Ipv4Len);
    set_address(32'h00000000);
    send_reply();

    pkt.delete();
    add_header(16'd0, 16'd2);
    add_record(TypeTxt, 16'd500);
    add_record(TypeA, Ipv4Len);
    send_reply();

    hold_go = 1'b1;
    while (sent < 1850) begin
      build_reply();
      send_reply();
    end
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/dnsa_pkg.sv
rtl/dnsa_in_reg.sv
rtl/dnsa_parser.sv
rtl/dnsa_out_reg.sv
rtl/dns_a_record_extractor.sv
rtl/dnsa_checker.sv
tb/sv/dnsa_checker.sv
tb/sv/tb.sv
